@@ rtl/pie_pkg.sv @@
// Shared widths and the per-axis stage control type of the particle integrator.
package pie_pkg;

   localparam int VAL_W   = 32;  // position, velocity, age, lifetime
   localparam int DT_W    = 20;  // step time, Q4.16
   localparam int DRAG_W  = 16;  // drag coefficient, Q8.8
   localparam int X_W     = DRAG_W + DT_W;  // drag * dt, Q12.24
   localparam int X_LIM_W = 29;  // table covers drag * dt below 32.0

   // Load enables of the four per-axis stages.
   typedef struct packed {
      logic ld_mul;
      logic ld_scale;
      logic ld_move;
      logic ld_out;
   } axis_ctl_type;

endpackage

@@ rtl/pie_lut.sv @@
// Interpolation table of exp(-x) in unsigned Q1.31 with two registered read ports.
module pie_lut #(
   parameter int ENTRIES = 256,
   localparam int ADR_W = $clog2(ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [ADR_W-1:0] hi_adr,
   input  logic [ADR_W-1:0] lo_adr,
   output logic [31:0]      hi_data,
   output logic [31:0]      lo_data
);

   localparam int          TAYLOR_TERMS = 24;
   localparam logic [63:0] ONE_Q31      = 64'd1 << 31;
   localparam logic [63:0] HALF_Q31     = 64'd1 << 30;
   localparam logic [63:0] HALF_STEP    = (64'd1 << 35) / ENTRIES;

   // exp(-h) per table step, as the square of a Taylor series for exp(-h/2)
   function automatic logic [63:0] ratio_of(input logic [63:0] g);
      logic [63:0] term;
      logic [63:0] sum;
      term = ONE_Q31;
      sum  = ONE_Q31;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = ((term * g) >> 31) / 64'(n);
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return (sum * sum + HALF_Q31) >> 31;
   endfunction

   // entry k: ratio raised to the k-th power with rounding at each step
   function automatic logic [31:0] power_of(input logic [63:0] r, input int k);
      logic [63:0] e;
      e = ONE_Q31;
      for (int i = 1; i <= k; i++) begin
         e = (e * r + HALF_Q31) >> 31;
      end
      return e[31:0];
   endfunction

   localparam logic [63:0] RATIO = ratio_of(HALF_STEP);

   logic [31:0] rom_w [0:ENTRIES];
   logic [31:0] hi_ff;
   logic [31:0] lo_ff;

   for (genvar k = 0; k <= ENTRIES; k++) begin : g_rom
      localparam logic [31:0] VALUE = power_of(RATIO, k);
      assign rom_w[k] = VALUE;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hi_ff <= rom_w[hi_adr];
         lo_ff <= rom_w[lo_adr];
      end
   end

   assign hi_data = hi_ff;
   assign lo_data = lo_ff;

endmodule

@@ rtl/pie_axis.sv @@
// One axis lane: drag scaling of the velocity, then the position step.
module pie_axis (
   input  logic                                clock,
   input  pie_pkg::axis_ctl_type               ctl,
   input  logic        [pie_pkg::VAL_W-1:0]    factor,
   input  logic signed [pie_pkg::VAL_W-1:0]    pos_in,
   input  logic signed [pie_pkg::VAL_W-1:0]    vel_in,
   input  logic        [pie_pkg::VAL_W-1:0]    vabs_in,
   input  logic                                scale,
   input  logic        [pie_pkg::DT_W-1:0]     dt,
   input  logic                                apply,
   output logic signed [pie_pkg::VAL_W-1:0]    new_pos,
   output logic signed [pie_pkg::VAL_W-1:0]    new_vel
);

   localparam int VW = pie_pkg::VAL_W;
   localparam int MW = 2 * VW;               // |v| * factor
   localparam int PW = VW + pie_pkg::DT_W;   // |v'| * dt
   localparam int SW = VW + 6;               // position sum with headroom

   logic        [MW-1:0] prod6_ff;
   logic signed [VW-1:0] pos6_ff;
   logic signed [VW-1:0] vel6_ff;
   logic        [VW-1:0] vabs6_ff;

   logic        [MW-1:0] rnd7;
   logic        [VW-1:0] q7;
   logic signed [VW-1:0] vel7_in;
   logic        [VW-1:0] mag7_in;
   logic signed [VW-1:0] pos7_ff;
   logic signed [VW-1:0] vel7_ff;
   logic        [VW-1:0] mag7_ff;

   logic        [PW-1:0] prod8_ff;
   logic signed [VW-1:0] pos8_ff;
   logic signed [VW-1:0] vel8_ff;

   logic        [PW-1:0] rnd9;
   logic        [PW-17:0] dist9;
   logic signed [SW-1:0] sum9;
   logic signed [VW-1:0] sat9;
   logic signed [VW-1:0] pos9_in;
   logic signed [VW-1:0] pos9_ff;
   logic signed [VW-1:0] vel9_ff;

   // round half away from zero on the magnitude, then restore the sign
   always_comb begin
      rnd7    = prod6_ff + (MW'(1) << 30);
      q7      = rnd7[VW+30:31];
      vel7_in = vel6_ff;
      mag7_in = vabs6_ff;
      if (scale) begin
         vel7_in = vel6_ff[VW-1] ? -signed'(q7) : signed'(q7);
         mag7_in = q7;
      end
   end

   always_comb begin
      rnd9  = prod8_ff + (PW'(1) << 15);
      dist9 = rnd9[PW-1:16];
      if (vel8_ff[VW-1]) begin
         sum9 = SW'(pos8_ff) - signed'(SW'(dist9));
      end else begin
         sum9 = SW'(pos8_ff) + signed'(SW'(dist9));
      end
      sat9 = sum9[VW-1:0];
      if (sum9[SW-1:VW-1] != {(SW-VW+1){sum9[VW-1]}}) begin
         sat9 = sum9[SW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end
      pos9_in = apply ? sat9 : pos8_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_mul) begin
         prod6_ff <= MW'(vabs_in) * MW'(factor);
         pos6_ff  <= pos_in;
         vel6_ff  <= vel_in;
         vabs6_ff <= vabs_in;
      end
      if (ctl.ld_scale) begin
         pos7_ff <= pos6_ff;
         vel7_ff <= vel7_in;
         mag7_ff <= mag7_in;
      end
      if (ctl.ld_move) begin
         prod8_ff <= PW'(mag7_ff) * PW'(dt);
         pos8_ff  <= pos7_ff;
         vel8_ff  <= vel7_ff;
      end
      if (ctl.ld_out) begin
         pos9_ff <= pos9_in;
         vel9_ff <= vel8_ff;
      end
   end

   assign new_pos = pos9_ff;
   assign new_vel = vel9_ff;

endmodule

@@ rtl/particle_integrate_expire.sv @@
// Top level: one semi-implicit Euler step with exponential drag and expiry by age.
//
//  channel | ports                      | direction | word
//  --------+----------------------------+-----------+------------------------------------
//  req     | req_valid / req_stall      | in        | dt, position, velocity, drag, age, life
//  rsp     | rsp_valid / rsp_stall      | out       | expired, position, velocity, age
//
//  One word enters per clock while no stall holds the pipe.
//  The table lookup, its interpolation multiply and the two multiplies per axis
//  (velocity by factor, velocity by dt) each get a stage of their own.
//  Each stage loads when it is empty or the one after it moves, so bubbles
//  close up under a stall and nothing is dropped or repeated.
//  Reset clears the valid bits only; the exp table is a constant built at elaboration.
module particle_integrate_expire #(
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic        [pie_pkg::DT_W-1:0]    req_step_time,
   input  logic signed [pie_pkg::VAL_W-1:0]   req_pos_x,
   input  logic signed [pie_pkg::VAL_W-1:0]   req_pos_y,
   input  logic signed [pie_pkg::VAL_W-1:0]   req_pos_z,
   input  logic signed [pie_pkg::VAL_W-1:0]   req_vel_x,
   input  logic signed [pie_pkg::VAL_W-1:0]   req_vel_y,
   input  logic signed [pie_pkg::VAL_W-1:0]   req_vel_z,
   input  logic        [pie_pkg::DRAG_W-1:0]  req_drag_coef,
   input  logic        [pie_pkg::VAL_W-1:0]   req_age_now,
   input  logic        [pie_pkg::VAL_W-1:0]   req_lifetime,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_expired,
   output logic signed [pie_pkg::VAL_W-1:0]   rsp_new_pos_x,
   output logic signed [pie_pkg::VAL_W-1:0]   rsp_new_pos_y,
   output logic signed [pie_pkg::VAL_W-1:0]   rsp_new_pos_z,
   output logic signed [pie_pkg::VAL_W-1:0]   rsp_new_vel_x,
   output logic signed [pie_pkg::VAL_W-1:0]   rsp_new_vel_y,
   output logic signed [pie_pkg::VAL_W-1:0]   rsp_new_vel_z,
   output logic        [pie_pkg::VAL_W-1:0]   rsp_new_age
);

   localparam int VW      = pie_pkg::VAL_W;
   localparam int XL      = pie_pkg::X_LIM_W;
   localparam int STAGES  = 9;
   localparam int LANES   = 3;
   localparam int HEAD    = 5;   // stages that carry the axis words in the top level
   localparam int IDX_W   = $clog2(EXP_TABLE_ENTRIES);
   localparam int ADR_W   = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int P_W     = XL + IDX_W;       // x * entries, below entries * 2^29
   localparam int IP_W    = VW + XL;          // interpolation product

   localparam logic [P_W-1:0]   ENTRIES_P = P_W'(EXP_TABLE_ENTRIES);
   localparam logic [ADR_W-1:0] LAST_ADR  = ADR_W'(EXP_TABLE_ENTRIES);

   // per-word flags and fields that ride along the whole pipe
   typedef struct packed {
      logic [pie_pkg::DT_W-1:0] dt;
      logic [VW-1:0]            new_age;
      logic                     expired;
      logic                     apply;    // step taken: scale and move
      logic                     scale;    // drag applies to the velocity
   } side_type;

   // pipe control: one valid bit per stage; one load enable per stage plus one for the output side
   logic [STAGES:1]   vld_ff;
   logic [STAGES+1:1] ld;

   side_type side_in;
   side_type side_ff [1:STAGES];

   // stage 1: age, expiry, drag * dt, velocity magnitudes
   logic [VW:0]                age_sum;
   logic                       step_zero;
   logic [pie_pkg::X_W-1:0]    x_in;
   logic [pie_pkg::X_W-1:0]    x1_ff;
   logic signed [VW-1:0]       pos_in  [LANES];
   logic signed [VW-1:0]       vel_in  [LANES];
   logic        [VW-1:0]       vabs_in [LANES];
   logic signed [VW-1:0]       pos_ff  [1:HEAD][LANES];
   logic signed [VW-1:0]       vel_ff  [1:HEAD][LANES];
   logic        [VW-1:0]       vabs_ff [1:HEAD][LANES];

   // stage 2: table addresses and interpolation fraction
   logic                       beyond2;
   logic [P_W-1:0]             p2;
   logic [ADR_W-1:0]           idx2;
   logic [ADR_W-1:0]           hi_adr2_ff;
   logic [ADR_W-1:0]           lo_adr2_ff;
   logic [XL-1:0]              frac2_ff;

   // stage 3: table words
   logic [VW-1:0]              hi3;
   logic [VW-1:0]              lo3;
   logic [XL-1:0]              frac3_ff;

   // stage 4 and 5: interpolation
   logic [IP_W-1:0]            prod4_ff;
   logic [VW-1:0]              hi4_ff;
   logic [IP_W-1:0]            rnd5;
   logic [VW-1:0]              factor5_ff;

   pie_pkg::axis_ctl_type      axis_ctl;
   logic signed [VW-1:0]       lane_pos [LANES];
   logic signed [VW-1:0]       lane_vel [LANES];

   // Walk back from the output: a stage loads when empty or when its successor moves.
   always_comb begin
      ld[STAGES+1] = !rsp_stall;
      for (int k = STAGES; k >= 1; k--) begin
         ld[k] = !vld_ff[k] || ld[k+1];
      end
   end

   assign req_stall = !ld[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (ld[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Age sum saturates; zero step never expires and leaves everything alone.
   always_comb begin
      pos_in[0] = req_pos_x;
      pos_in[1] = req_pos_y;
      pos_in[2] = req_pos_z;
      vel_in[0] = req_vel_x;
      vel_in[1] = req_vel_y;
      vel_in[2] = req_vel_z;
      for (int j = 0; j < LANES; j++) begin
         vabs_in[j] = vel_in[j][VW-1] ? unsigned'(-vel_in[j]) : unsigned'(vel_in[j]);
      end
      age_sum         = {1'b0, req_age_now} + (VW+1)'(req_step_time);
      step_zero       = (req_step_time == '0);
      side_in.dt      = req_step_time;
      side_in.new_age = age_sum[VW] ? '1 : age_sum[VW-1:0];
      side_in.expired = !step_zero && (side_in.new_age >= req_lifetime);
      side_in.apply   = !step_zero && !side_in.expired;
      side_in.scale   = side_in.apply && (req_drag_coef != '0);
      x_in            = pie_pkg::X_W'(req_drag_coef) * pie_pkg::X_W'(req_step_time);
   end

   // Past the table's end, read the last entry twice with a zero fraction.
   always_comb begin
      beyond2 = |x1_ff[pie_pkg::X_W-1:XL];
      p2      = P_W'(x1_ff[XL-1:0]) * ENTRIES_P;
      idx2    = ADR_W'(p2[P_W-1:XL]);
   end

   always_comb begin
      rnd5 = prod4_ff + (IP_W'(1) << (XL - 1));
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         side_ff[1] <= side_in;
         x1_ff      <= x_in;
         for (int j = 0; j < LANES; j++) begin
            pos_ff[1][j]  <= pos_in[j];
            vel_ff[1][j]  <= vel_in[j];
            vabs_ff[1][j] <= vabs_in[j];
         end
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (ld[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
      for (int k = 2; k <= HEAD; k++) begin
         if (ld[k]) begin
            for (int j = 0; j < LANES; j++) begin
               pos_ff[k][j]  <= pos_ff[k-1][j];
               vel_ff[k][j]  <= vel_ff[k-1][j];
               vabs_ff[k][j] <= vabs_ff[k-1][j];
            end
         end
      end
      if (ld[2]) begin
         hi_adr2_ff <= beyond2 ? LAST_ADR : idx2;
         lo_adr2_ff <= beyond2 ? LAST_ADR : idx2 + ADR_W'(1);
         frac2_ff   <= beyond2 ? '0 : p2[XL-1:0];
      end
      if (ld[3]) begin
         frac3_ff <= frac2_ff;
      end
      if (ld[4]) begin
         prod4_ff <= IP_W'(hi3 - lo3) * IP_W'(frac3_ff);
         hi4_ff   <= hi3;
      end
      if (ld[5]) begin
         factor5_ff <= hi4_ff - rnd5[IP_W-1:XL];
      end
   end

   pie_lut #(
      .ENTRIES (EXP_TABLE_ENTRIES)
   ) u_lut (
      .clock   (clock),
      .rd_en   (ld[3]),
      .hi_adr  (hi_adr2_ff),
      .lo_adr  (lo_adr2_ff),
      .hi_data (hi3),
      .lo_data (lo3)
   );

   assign axis_ctl = '{ld_mul: ld[6], ld_scale: ld[7], ld_move: ld[8], ld_out: ld[9]};

   // Each lane picks up its flags from the stage whose output it uses.
   for (genvar j = 0; j < LANES; j++) begin : g_axis
      pie_axis u_axis (
         .clock   (clock),
         .ctl     (axis_ctl),
         .factor  (factor5_ff),
         .pos_in  (pos_ff[HEAD][j]),
         .vel_in  (vel_ff[HEAD][j]),
         .vabs_in (vabs_ff[HEAD][j]),
         .scale   (side_ff[6].scale),
         .dt      (side_ff[7].dt),
         .apply   (side_ff[8].apply),
         .new_pos (lane_pos[j]),
         .new_vel (lane_vel[j])
      );
   end

   assign rsp_valid     = vld_ff[STAGES];
   assign rsp_expired   = side_ff[STAGES].expired;
   assign rsp_new_age   = side_ff[STAGES].new_age;
   assign rsp_new_pos_x = lane_pos[0];
   assign rsp_new_pos_y = lane_pos[1];
   assign rsp_new_pos_z = lane_pos[2];
   assign rsp_new_vel_x = lane_vel[0];
   assign rsp_new_vel_y = lane_vel[1];
   assign rsp_new_vel_z = lane_vel[2];

endmodule

@@ rtl/pie_checker.sv @@
// Port checks of the particle integrator, bound to the top level.
module pie_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_expired,
   input logic        [pie_pkg::VAL_W-1:0]   rsp_new_age,
   input logic signed [pie_pkg::VAL_W-1:0]   rsp_new_pos_x
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_age))
      else $error("stalled result word dropped or changed");

   a_rsp_pos_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_pos_x))
      else $error("stalled position changed");

   // a free output side must never hold back the input
   a_no_false_stall: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // expiry needs a nonzero step, so the age cannot be zero
   a_expired_age: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expired |-> rsp_new_age != '0)
      else $error("expired word with zero age");

endmodule

bind particle_integrate_expire pie_checker u_pie_checker (.*);
